[rtl/core/cppm_pkg.sv]
// Shared types and constants for the CPPM frame decoder.
// No dependencies; imported by cppm_frame_decoder.
`timescale 1ns / 1ps

package cppm_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_IGNORED  = 3'd1,
    ST_BAD      = 3'd2,
    ST_ACCEPTED = 3'd3,
    ST_DROPPED  = 3'd4
  } status_t;

  // Configuration register indices
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_PULSE  = 2'd0,
    REG_MAX_PULSE  = 2'd1,
    REG_SYNC_PULSE = 2'd2
  } cfg_reg_t;

  localparam int TIME_W  = 32;
  localparam int PULSE_W = 16;
  localparam int CHAN_W  = 3;

  // Most frame values emitted per sync
  localparam int MAX_EMIT = 8;

  localparam logic [PULSE_W-1:0] MIN_PULSE_RST  = 16'd700;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST  = 16'd2250;
  localparam logic [PULSE_W-1:0] SYNC_PULSE_RST = 16'd7500;
  localparam logic [PULSE_W-1:0] SLOT_RST       = 16'd1500;

endpackage

[rtl/core/cppm_frame_decoder.sv]
// CPPM frame decoder top level: width stage, classifier, capture memory, frame sweep.
// Depends on cppm_pkg.
`timescale 1ns / 1ps

// Takes microsecond timestamps of rising edges on the in_ channel, one beat each, and
// turns the gap to the previous edge into a pulse width. Widths below min_pulse or
// between max_pulse and sync_pulse bump a wrapping 16-bit error count and drop the rest
// of the frame; a width at or above sync_pulse ends the frame; anything else lands in
// the next capture slot if the frame is not dropped and a slot is free. Every edge gives
// one status beat on out_, except an accepted sync, which gives one beat per channel
// (min(NUM_CHANNELS, 8) beats, out_last on the final one). Slot values live in a
// single-port-read capture memory of NUM_CHANNELS words; slots never written since
// reset read as 1500 via per-slot valid flags, so no clearing pass is needed. Edges
// that give a single beat flow at one per cycle while out_stall is low and no sweep
// runs; an accepted sync holds the classifier while the sweep reads the memory one
// slot per cycle while out_stall is low. Throughput is bounded by the output port, one
// beat per cycle, and by the memory read port during the sweep. cfg_ready is always
// high; registers should only be written while the block is idle.
module cppm_frame_decoder
  import cppm_pkg::*;
#(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // edge input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [TIME_W-1:0]    in_edge_time,
  // results
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic [CHAN_W-1:0]    out_channel,
  output logic [PULSE_W-1:0]   out_value,
  output logic [PULSE_W-1:0]   out_error_count,
  output logic                 out_last,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PULSE_W-1:0]   cfg_data
);

  localparam int AW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CW   = $clog2(NUM_CHANNELS + 1);
  localparam int EMIT = (NUM_CHANNELS < MAX_EMIT) ? NUM_CHANNELS : MAX_EMIT;
  localparam logic [CHAN_W-1:0] LAST_IDX = CHAN_W'(EMIT - 1);
  localparam logic [CW-1:0]     CC_FULL  = CW'(NUM_CHANNELS);

  // ---------------------------------------------------------------- config
  logic [PULSE_W-1:0] min_r, max_r, sync_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= MIN_PULSE_RST;
      max_r  <= MAX_PULSE_RST;
      sync_r <= SYNC_PULSE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_PULSE:  min_r  <= cfg_data;
        REG_MAX_PULSE:  max_r  <= cfg_data;
        REG_SYNC_PULSE: sync_r <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  logic                 w_valid_r;
  logic [TIME_W-1:0]    w_width_r;
  logic [TIME_W-1:0]    prev_edge_r;
  logic [CW-1:0]        cc_r, cc_nxt;
  logic                 dropped_r, dropped_nxt;
  logic [PULSE_W-1:0]   err_r, err_nxt;

  // frame sweep sequencer and memory read stage
  logic                 seq_busy_r;
  logic [CHAN_W-1:0]    seq_idx_r;
  logic                 rd_full_r;
  logic [CHAN_W-1:0]    rd_idx_r;
  logic                 rd_last_r;
  logic                 rd_vld_r;
  logic [PULSE_W-1:0]   rd_data_r;

  // capture memory and per-slot written flags
  logic [PULSE_W-1:0]   cap_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] slot_vld_r;

  // output register
  logic                 out_valid_r;
  status_t              out_status_r, out_status_nxt;
  logic [CHAN_W-1:0]    out_channel_r, out_channel_nxt;
  logic [PULSE_W-1:0]   out_value_r, out_value_nxt;
  logic [PULSE_W-1:0]   out_err_r, out_err_nxt;
  logic                 out_last_r, out_last_nxt;

  // ---------------------------------------------------------------- control
  logic in_accept, out_free, c_fire, c_frame, rd_issue, rd_take, mem_we;
  logic [AW-1:0] waddr, raddr;

  // classifier
  logic [PULSE_W-1:0] sat;
  logic bad, is_sync, drop_eff, can_store;

  assign out_free  = !out_valid_r || !out_stall;
  assign rd_take   = rd_full_r && out_free;
  // classifier waits out a sweep; this also keeps memory writes off the read port
  assign c_fire    = w_valid_r && !seq_busy_r && !rd_full_r && out_free;
  assign in_stall  = w_valid_r && !c_fire;
  assign in_accept = in_valid && !in_stall;
  assign rd_issue  = seq_busy_r && (!rd_full_r || rd_take);

  assign sat       = (|w_width_r[TIME_W-1:PULSE_W]) ? {PULSE_W{1'b1}} : w_width_r[PULSE_W-1:0];
  assign bad       = (w_width_r < {16'd0, min_r}) ||
                     ((w_width_r > {16'd0, max_r}) && (w_width_r < {16'd0, sync_r}));
  assign is_sync   = (w_width_r >= {16'd0, sync_r});
  assign drop_eff  = dropped_r || bad;
  assign can_store = !dropped_r && (cc_r < CC_FULL);
  assign c_frame   = is_sync && !drop_eff;

  assign mem_we    = c_fire && !is_sync && !bad && can_store;
  assign waddr     = cc_r[AW-1:0];
  assign raddr     = AW'(seq_idx_r);

  always_comb begin
    cc_nxt          = cc_r;
    dropped_nxt     = dropped_r;
    err_nxt         = err_r + {15'd0, bad};
    out_status_nxt  = ST_IGNORED;
    out_channel_nxt = '0;
    out_value_nxt   = sat;
    out_err_nxt     = err_nxt;
    out_last_nxt    = 1'b1;
    if (bad) dropped_nxt = 1'b1;
    if (is_sync) begin
      cc_nxt         = '0;
      dropped_nxt    = 1'b0;
      out_status_nxt = ST_DROPPED;   // unused when the frame is accepted
    end else if (bad) begin
      out_status_nxt = ST_BAD;
    end else if (can_store) begin
      out_status_nxt  = ST_STORED;
      out_channel_nxt = CHAN_W'(cc_r);
      cc_nxt          = cc_r + CW'(1);
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r   <= 1'b0;
      prev_edge_r <= '0;
      cc_r        <= '0;
      dropped_r   <= 1'b0;
      err_r       <= '0;
      seq_busy_r  <= 1'b0;
      seq_idx_r   <= '0;
      rd_full_r   <= 1'b0;
      slot_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // width stage
      if (in_accept) begin
        w_valid_r   <= 1'b1;
        prev_edge_r <= in_edge_time;
      end else if (c_fire) begin
        w_valid_r   <= 1'b0;
      end

      // classifier state
      if (c_fire) begin
        cc_r      <= cc_nxt;
        dropped_r <= dropped_nxt;
        err_r     <= err_nxt;
      end
      if (mem_we) slot_vld_r[waddr] <= 1'b1;

      // sweep sequencer
      if (c_fire && c_frame) begin
        seq_busy_r <= 1'b1;
        seq_idx_r  <= '0;
      end else if (rd_issue) begin
        if (seq_idx_r == LAST_IDX) seq_busy_r <= 1'b0;
        seq_idx_r <= seq_idx_r + CHAN_W'(1);
      end

      // read stage
      if (rd_issue)     rd_full_r <= 1'b1;
      else if (rd_take) rd_full_r <= 1'b0;

      // output register
      if ((c_fire && !c_frame) || rd_take) out_valid_r <= 1'b1;
      else if (out_free)                   out_valid_r <= 1'b0;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_accept) w_width_r <= in_edge_time - prev_edge_r;
    if (rd_issue) begin
      rd_idx_r  <= seq_idx_r;
      rd_last_r <= (seq_idx_r == LAST_IDX);
      rd_vld_r  <= slot_vld_r[raddr];
    end
    if (c_fire && !c_frame) begin
      out_status_r  <= out_status_nxt;
      out_channel_r <= out_channel_nxt;
      out_value_r   <= out_value_nxt;
      out_err_r     <= out_err_nxt;
      out_last_r    <= out_last_nxt;
    end else if (rd_take) begin
      out_status_r  <= ST_ACCEPTED;
      out_channel_r <= rd_idx_r;
      out_value_r   <= rd_vld_r ? rd_data_r : SLOT_RST;
      out_err_r     <= err_r;   // held steady for the whole sweep
      out_last_r    <= rd_last_r;
    end
  end

  // capture memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we)   cap_mem[waddr] <= sat;
    if (rd_issue) rd_data_r      <= cap_mem[raddr];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_channel     = out_channel_r;
  assign out_value       = out_value_r;
  assign out_error_count = out_err_r;
  assign out_last        = out_last_r;

  // ---------------------------------------------------------------- checks
  a_cc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cc_r <= CC_FULL)
    else $error("channel count beyond NUM_CHANNELS");

  a_err_stable_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    seq_busy_r |=> $stable(err_r))
    else $error("error count moved during a frame sweep");

  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (!seq_busy_r && !rd_full_r))
    else $error("capture write overlaps a frame sweep");

  a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_ACCEPTED) && out_last_r) |-> (out_channel_r == LAST_IDX))
    else $error("frame last mark on wrong channel");

endmodule
